@@ design/msi_pkg.sv @@
// Shared constants, types and helper functions for the multi-spin Ising update block.
// Depends on nothing; every other design file but msi_checker uses it.
package msi_pkg;

	// Lattice geometry.
	localparam int SIDE   = 64;
	localparam int NSITES = SIDE * SIDE;
	localparam int ADDR_W = $clog2(NSITES);
	localparam int AW1    = ADDR_W + 1;

	// Field widths.
	localparam int WORD_W    = 64;
	localparam int SITE_W    = 12;
	localparam int DRAW_W    = 16;
	localparam int THR_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Acceptance table layout: entry = edge * EDGE_STEP + spin * SPIN_STEP + count.
	localparam int N_BOND        = 4;
	localparam int CNT_W         = 3;
	localparam int TBL_SPIN_STEP = N_BOND + 1;
	localparam int TBL_EDGE_STEP = 2 * TBL_SPIN_STEP;
	localparam int N_ENTRY       = 2 * TBL_EDGE_STEP;
	localparam int ENTRY_W       = $clog2(N_ENTRY);
	localparam int THR_PER_REG   = 4;
	localparam int N_THR_REG     = N_ENTRY / THR_PER_REG;

	// Column extraction: site / SIDE by reciprocal multiply, then one correction step.
	localparam int RECIP_K = 24;
	localparam int RECIP   = (1 << RECIP_K) / SIDE;
	localparam int PROD_W  = SITE_W + RECIP_K;
	localparam int RB_W    = SITE_W + $clog2(SIDE + 1);

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [SITE_W-1:0]    site_t;
	typedef logic [DRAW_W-1:0]    draw_t;
	typedef logic [THR_W-1:0]     thr_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam word_t ALL_ONES = ~word_t'(0);

	typedef enum logic [1:0] {
		OP_WR_SPIN = 2'd0,
		OP_WR_COUP = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_RD_SPIN = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BOND_W = 2'd0,
		BOND_E = 2'd1,
		BOND_N = 2'd2,
		BOND_S = 2'd3
	} bond_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THR_A  = 3'd0,
		CFG_THR_B  = 3'd1,
		CFG_THR_C  = 3'd2,
		CFG_THR_D  = 3'd3,
		CFG_THR_E  = 3'd4,
		CFG_ALWAYS = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_RD2,
		ST_RD3,
		ST_CALC,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef logic [N_BOND-1:0][WORD_W-1:0] coup_row_t;

	typedef struct packed {
		thr_t [N_ENTRY-1:0]   thr;
		logic [N_ENTRY-1:0]   always_acc;
	} acc_cfg_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr_a;
		addr_t raddr_b;
	} spin_cmd_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		bond_t bond;
		word_t wdata;
		addr_t raddr;
	} coup_cmd_t;

	// Operands of one update, held by the sequencer for the flip logic.
	typedef struct packed {
		word_t     me;
		word_t     n_spin;
		word_t     s_spin;
		coup_row_t coup;
		logic      at_w;
		logic      at_e;
		draw_t     draw;
	} nbr_t;

	function automatic logic site_in_range(site_t s);
		return int'(s) < NSITES;
	endfunction

endpackage

@@ design/msi_req_if.sv @@
// Input channel of the Ising update block: one word per request.
// Depends on msi_pkg for field types.
interface msi_req_if;
	logic           valid;
	logic           ready;
	logic [1:0]     operation;
	msi_pkg::site_t site;
	logic [1:0]     bond;
	msi_pkg::word_t word;
	msi_pkg::draw_t random_draw;

	modport source(output valid, output operation, output site, output bond, output word,
		output random_draw, input ready);
	modport sink(input valid, input operation, input site, input bond, input word,
		input random_draw, output ready);
endinterface

@@ design/msi_rsp_if.sv @@
// Result channel of the Ising update block: one word per result.
// Depends on msi_pkg for field types.
interface msi_rsp_if;
	logic           valid;
	logic           ready;
	msi_pkg::word_t spin_word;
	msi_pkg::word_t flip_mask;

	modport source(output valid, output spin_word, output flip_mask, input ready);
	modport sink(input valid, input spin_word, input flip_mask, output ready);
endinterface

@@ design/msi_cfg_regs.sv @@
// Acceptance-table configuration registers: five threshold words and the always flags.
// Depends on msi_pkg.
module msi_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  msi_pkg::cfg_idx_t  cfg_index,
	input  msi_pkg::word_t     cfg_data,
	output msi_pkg::acc_cfg_t  acc_cfg
);
	import msi_pkg::*;

	word_t              thr_reg_q [N_THR_REG];
	logic [N_ENTRY-1:0] always_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < N_THR_REG; r++) begin
				thr_reg_q[r] <= '0;
			end
			always_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THR_A:  thr_reg_q[0] <= cfg_data;
				CFG_THR_B:  thr_reg_q[1] <= cfg_data;
				CFG_THR_C:  thr_reg_q[2] <= cfg_data;
				CFG_THR_D:  thr_reg_q[3] <= cfg_data;
				CFG_THR_E:  thr_reg_q[4] <= cfg_data;
				CFG_ALWAYS: always_q     <= cfg_data[N_ENTRY-1:0];
				default:    ;
			endcase
		end
	end

	// Entry r*4+k sits in bits 16k and up of threshold word r.
	always_comb begin
		for (int r = 0; r < N_THR_REG; r++) begin
			for (int k = 0; k < THR_PER_REG; k++) begin
				acc_cfg.thr[r*THR_PER_REG + k] = thr_reg_q[r][k*THR_W +: THR_W];
			end
		end
		acc_cfg.always_acc = always_q;
	end

endmodule

@@ design/msi_spin_mem.sv @@
// Spin word store: one write port, two read ports, registered read data.
// Depends on msi_pkg.
module msi_spin_mem (
	input  logic               clk,
	input  msi_pkg::spin_cmd_t cmd,
	output msi_pkg::word_t     rdata_a,
	output msi_pkg::word_t     rdata_b
);
	import msi_pkg::*;

	word_t mem [NSITES];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		rdata_a <= mem[cmd.raddr_a];
		rdata_b <= mem[cmd.raddr_b];
	end

endmodule

@@ design/msi_coup_mem.sv @@
// Coupling store: one row of four bond words per site, written one bond at a time.
// Depends on msi_pkg.
module msi_coup_mem (
	input  logic               clk,
	input  msi_pkg::coup_cmd_t cmd,
	output msi_pkg::coup_row_t rdata
);
	import msi_pkg::*;

	coup_row_t mem [NSITES];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr][cmd.bond] <= cmd.wdata;
		end
		rdata <= mem[cmd.raddr];
	end

endmodule

@@ design/msi_flip_logic.sv @@
// Per-lane Metropolis decision: unsatisfied-bond count, table entry and flip mask.
// Depends on msi_pkg.
module msi_flip_logic (
	input  msi_pkg::acc_cfg_t acc_cfg,
	input  msi_pkg::nbr_t     nbr,
	input  msi_pkg::word_t    w_spin,
	input  msi_pkg::word_t    e_spin,
	output msi_pkg::word_t    flips
);
	import msi_pkg::*;

	word_t              uw, ue, un, us;
	logic [N_ENTRY-1:0] acc;
	logic               edge_col;
	logic [CNT_W-1:0]   cnt [WORD_W];
	logic [ENTRY_W-1:0] idx [WORD_W];

	// Bonds leaving the lattice on the west or east side always count as unsatisfied.
	always_comb begin
		uw = nbr.at_w ? ALL_ONES : (nbr.coup[BOND_W] ^ w_spin ^ nbr.me);
		ue = nbr.at_e ? ALL_ONES : (nbr.coup[BOND_E] ^ e_spin ^ nbr.me);
		un = nbr.coup[BOND_N] ^ nbr.n_spin ^ nbr.me;
		us = nbr.coup[BOND_S] ^ nbr.s_spin ^ nbr.me;
		edge_col = nbr.at_w | nbr.at_e;
		for (int i = 0; i < N_ENTRY; i++) begin
			acc[i] = (nbr.draw < acc_cfg.thr[i]) || acc_cfg.always_acc[i];
		end
	end

	always_comb begin
		for (int l = 0; l < WORD_W; l++) begin
			cnt[l] = CNT_W'(uw[l]) + CNT_W'(ue[l]) + CNT_W'(un[l]) + CNT_W'(us[l]);
			idx[l] = (edge_col ? ENTRY_W'(TBL_EDGE_STEP) : '0)
				+ (nbr.me[l] ? ENTRY_W'(TBL_SPIN_STEP) : '0)
				+ ENTRY_W'(cnt[l]);
			flips[l] = acc[idx[l]];
		end
	end

endmodule

@@ design/msi_ctrl.sv @@
// Sequencer of the Ising update block: request capture, memory reads, write-back
// and the result register. Depends on msi_pkg, msi_req_if and msi_rsp_if.
module msi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	msi_req_if.sink            req,
	msi_rsp_if.source          rsp,
	output msi_pkg::spin_cmd_t spin_cmd,
	input  msi_pkg::word_t     spin_rd_a,
	input  msi_pkg::word_t     spin_rd_b,
	output msi_pkg::coup_cmd_t coup_cmd,
	input  msi_pkg::coup_row_t coup_rd,
	output msi_pkg::nbr_t      nbr,
	input  msi_pkg::word_t     flips
);
	import msi_pkg::*;

	state_t    state_q, state_nx;
	op_t       op_q;
	site_t     site_q;
	bond_t     bond_q;
	word_t     word_q;
	draw_t     draw_q;
	site_t     row_q;
	logic      at_w_q, at_e_q;
	word_t     me_q, n_q, s_q;
	coup_row_t coup_q;
	word_t     res_spin_q, res_flip_q;
	logic      out_valid_q;
	word_t     out_spin_q, out_flip_q;

	addr_t              addr, north_addr, south_addr, west_addr, east_addr;
	logic [AW1-1:0]     south_sum;
	logic               in_range;
	logic [PROD_W-1:0]  prod;
	logic [RB_W-1:0]    rowbase;
	site_t              col_est, col;
	logic               out_load;

	// Address arithmetic; north and south wrap, west and east stay on the site at the edges.
	always_comb begin
		in_range   = site_in_range(site_q);
		addr       = ADDR_W'(site_q);
		north_addr = (addr < ADDR_W'(SIDE)) ? addr + ADDR_W'(NSITES - SIDE)
			: addr - ADDR_W'(SIDE);
		south_sum  = AW1'(addr) + AW1'(SIDE);
		south_addr = (south_sum < AW1'(NSITES)) ? ADDR_W'(south_sum)
			: ADDR_W'(south_sum - AW1'(NSITES));
		west_addr  = at_w_q ? addr : addr - ADDR_W'(1);
		east_addr  = at_e_q ? addr : addr + ADDR_W'(1);
		prod       = PROD_W'(site_q) * PROD_W'(RECIP);
		rowbase    = RB_W'(row_q) * RB_W'(SIDE);
		col_est    = SITE_W'(RB_W'(site_q) - rowbase);
		col        = (col_est >= SITE_W'(SIDE)) ? col_est - SITE_W'(SIDE) : col_est;
		out_load   = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_nx = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (!in_range || op_q == OP_WR_SPIN) state_nx = ST_DONE;
				else if (op_q == OP_UPDATE) state_nx = ST_RD2;
				else state_nx = ST_WAIT;
			end
			ST_RD2:  state_nx = ST_RD3;
			ST_RD3:  state_nx = ST_CALC;
			ST_CALC: state_nx = ST_DONE;
			ST_WAIT: state_nx = ST_DONE;
			ST_DONE: begin
				if (out_load) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready        = (state_q == ST_IDLE);
		spin_cmd.we      = 1'b0;
		spin_cmd.waddr   = addr;
		spin_cmd.wdata   = word_q;
		spin_cmd.raddr_a = addr;
		spin_cmd.raddr_b = north_addr;
		coup_cmd.we      = 1'b0;
		coup_cmd.waddr   = addr;
		coup_cmd.bond    = bond_q;
		coup_cmd.wdata   = word_q;
		coup_cmd.raddr   = addr;
		case (state_q)
			ST_ISSUE: begin
				spin_cmd.we = in_range && (op_q == OP_WR_SPIN);
				coup_cmd.we = in_range && (op_q == OP_WR_COUP);
			end
			ST_RD2: begin
				spin_cmd.raddr_a = south_addr;
			end
			ST_RD3: begin
				spin_cmd.raddr_a = west_addr;
				spin_cmd.raddr_b = east_addr;
			end
			ST_CALC: begin
				spin_cmd.we    = 1'b1;
				spin_cmd.wdata = me_q ^ flips;
			end
			default: ;
		endcase
	end

	always_comb begin
		nbr.me     = me_q;
		nbr.n_spin = n_q;
		nbr.s_spin = s_q;
		nbr.coup   = coup_q;
		nbr.at_w   = at_w_q;
		nbr.at_e   = at_e_q;
		nbr.draw   = draw_q;
		rsp.valid     = out_valid_q;
		rsp.spin_word = out_spin_q;
		rsp.flip_mask = out_flip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q   <= op_t'(req.operation);
					site_q <= req.site;
					bond_q <= bond_t'(req.bond);
					word_q <= req.word;
					draw_q <= req.random_draw;
				end
			end
			ST_ISSUE: begin
				row_q <= prod[RECIP_K +: SITE_W];
				if (!in_range) begin
					res_spin_q <= '0;
					res_flip_q <= '0;
				end else begin
					res_spin_q <= word_q;
					res_flip_q <= '0;
				end
			end
			ST_RD2: begin
				me_q   <= spin_rd_a;
				n_q    <= spin_rd_b;
				coup_q <= coup_rd;
				at_w_q <= (col == '0);
				at_e_q <= (col == SITE_W'(SIDE - 1));
			end
			ST_RD3: begin
				s_q <= spin_rd_a;
			end
			ST_CALC: begin
				res_spin_q <= me_q ^ flips;
				res_flip_q <= flips;
			end
			ST_WAIT: begin
				res_spin_q <= spin_rd_a;
				res_flip_q <= '0;
			end
			default: ;
		endcase
		if (out_load) begin
			out_spin_q <= res_spin_q;
			out_flip_q <= res_flip_q;
		end
	end

endmodule

@@ design/multispin_ising_metropolis_update.sv @@
// Multi-spin-coded Metropolis update for a 2D Ising spin glass lattice.
// Depends on msi_pkg, msi_req_if, msi_rsp_if and all msi_* submodules.
//
// The block keeps a SIDE x SIDE lattice of 64-bit spin words (bit k is replica k) in a
// two-read-port spin memory, and four coupling words per site in a coupling memory whose
// rows hold all four bonds of a site. A request word either writes a spin word, writes
// one coupling word, reads a spin word, or updates a site; every request gives exactly
// one result word with the site's spin word afterwards and the mask of flipped lanes.
// The block handles one request at a time. A spin write goes through the issue and done
// states, a spin read or coupling write through issue, wait and done, an update through
// issue, RD2, RD3, calc and done: the two spin read ports fetch the five spin words in
// issue, RD2 and RD3, calc computes and writes back, and done loads the result register.
// Results wait in that register, so a new request is taken while the previous result is
// still unread; a request that finishes while the register is still full waits for it.
// The memories need no clearing pass: reading a word that was never written is not
// allowed. Thresholds and always flags must be written only while the block is idle.
module multispin_ising_metropolis_update (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  msi_pkg::cfg_idx_t cfg_index,
	input  msi_pkg::word_t    cfg_data,
	msi_req_if.sink           req,
	msi_rsp_if.source         rsp
);
	import msi_pkg::*;

	acc_cfg_t  acc_cfg;
	spin_cmd_t spin_cmd;
	coup_cmd_t coup_cmd;
	word_t     spin_rd_a, spin_rd_b;
	coup_row_t coup_rd;
	nbr_t      nbr;
	word_t     flips;

	// Threshold and always-accept registers feeding the acceptance table.
	msi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc_cfg   (acc_cfg)
	);

	// Sequencer: it owns both memories' ports, so read and write-back never overlap
	// for one site and the next request always reads the written-back word.
	msi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.spin_cmd  (spin_cmd),
		.spin_rd_a (spin_rd_a),
		.spin_rd_b (spin_rd_b),
		.coup_cmd  (coup_cmd),
		.coup_rd   (coup_rd),
		.nbr       (nbr),
		.flips     (flips)
	);

	msi_spin_mem u_spin_mem (
		.clk     (clk),
		.cmd     (spin_cmd),
		.rdata_a (spin_rd_a),
		.rdata_b (spin_rd_b)
	);

	msi_coup_mem u_coup_mem (
		.clk   (clk),
		.cmd   (coup_cmd),
		.rdata (coup_rd)
	);

	// The west and east neighbor words arrive straight from the spin memory in the
	// compute cycle; the rest were captured by the sequencer.
	msi_flip_logic u_flip (
		.acc_cfg (acc_cfg),
		.nbr     (nbr),
		.w_spin  (spin_rd_a),
		.e_spin  (spin_rd_b),
		.flips   (flips)
	);

endmodule

@@ design/msi_checker.sv @@
// Port-level checks of the Ising update block, attached to the top level by bind.
// Depends on nothing but the top level's ports.
module msi_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready
);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped while stalled");

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in work");

	// No request completes in the cycle right after it is taken.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	// Leaving reset, no result is offered.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result offered out of reset");

endmodule

bind multispin_ising_metropolis_update msi_checker u_msi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

@@ tb/msi_update_checker.sv @@
`timescale 1ns / 100ps
// Checker for the multi-spin Ising update block: mirrors the lattice, couplings and
// acceptance table, predicts every result word and compares it with the block's output.
// Depends on msi_pkg, msi_req_if and msi_rsp_if.
module msi_update_checker
	import msi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  word_t    cfg_data,
	msi_req_if       req,
	msi_rsp_if       rsp,
	output int       outstanding,
	output int       errors
);

	typedef struct packed {
		word_t spin_word;
		word_t flip_mask;
	} site_result_t;

	localparam int PRINT_CAP = 100;

	word_t              lattice   [NSITES];
	word_t              couplings [NSITES * N_BOND];
	thr_t               thr_tab   [N_ENTRY];
	logic [N_ENTRY-1:0] always_acc;
	site_result_t       in_flight [$];
	site_result_t       oldest;
	int                 fail_count;

	assign errors = fail_count;

	initial begin
		foreach (lattice[i]) lattice[i] = '0;
		foreach (couplings[i]) couplings[i] = '0;
		foreach (thr_tab[i]) thr_tab[i] = '0;
		always_acc  = '0;
		fail_count  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(string what, word_t got, word_t want);
		if (fail_count < PRINT_CAP)
			$display("[%0t] %s: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	// One Metropolis step on a site, all 64 lanes at once. Writes the new spin word back.
	function automatic word_t metropolis_flips(int s, draw_t draw);
		int                 col, n_site, s_site, cnt, idx, lane, i;
		logic               at_edge;
		word_t              me, uw, ue, un, us, flips;
		logic [N_ENTRY-1:0] accept;
		col     = s % SIDE;
		at_edge = (col == 0) || (col == SIDE - 1);
		me      = lattice[s];
		n_site  = (s < SIDE) ? s + NSITES - SIDE : s - SIDE;
		s_site  = (s + SIDE < NSITES) ? s + SIDE : s + SIDE - NSITES;
		// Open boundary in the row direction: a missing neighbor counts as unsatisfied.
		uw = ALL_ONES;
		ue = ALL_ONES;
		if (col != 0)
			uw = couplings[s * N_BOND + int'(BOND_W)] ^ lattice[s - 1] ^ me;
		if (col != SIDE - 1)
			ue = couplings[s * N_BOND + int'(BOND_E)] ^ lattice[s + 1] ^ me;
		un = couplings[s * N_BOND + int'(BOND_N)] ^ lattice[n_site] ^ me;
		us = couplings[s * N_BOND + int'(BOND_S)] ^ lattice[s_site] ^ me;
		for (i = 0; i < N_ENTRY; i++)
			accept[i] = (draw < thr_tab[i]) || always_acc[i];
		flips = '0;
		for (lane = 0; lane < WORD_W; lane++) begin
			cnt = int'(uw[lane]) + int'(ue[lane]) + int'(un[lane]) + int'(us[lane]);
			idx = int'(at_edge) * TBL_EDGE_STEP + int'(me[lane]) * TBL_SPIN_STEP + cnt;
			flips[lane] = accept[idx];
		end
		lattice[s] = me ^ flips;
		return flips;
	endfunction

	function automatic site_result_t apply_request(op_t op, site_t site, bond_t b, word_t w,
		draw_t d);
		site_result_t r;
		int           s;
		r = '0;
		s = int'(site);
		if (s >= NSITES)
			return r;
		case (op)
			OP_WR_SPIN: lattice[s] = w;
			OP_WR_COUP: couplings[s * N_BOND + int'(b)] = w;
			OP_UPDATE:  r.flip_mask = metropolis_flips(s, d);
			default:    ;
		endcase
		r.spin_word = lattice[s];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_ALWAYS)
					always_acc = cfg_data[N_ENTRY-1:0];
				else if (cfg_index <= CFG_THR_E)
					for (int k = 0; k < THR_PER_REG; k++)
						thr_tab[int'(cfg_index) * THR_PER_REG + k] = cfg_data[THR_W*k +: THR_W];
			end
			// Results come out only after their request has passed through the sequencer, so the
			// oldest prediction is retired before this edge's request is predicted.
			if (rsp.valid && rsp.ready) begin
				if (in_flight.size() == 0) begin
					report_mismatch("result word with nothing outstanding", rsp.spin_word, '0);
				end else begin
					oldest = in_flight.pop_front();
					if (rsp.spin_word !== oldest.spin_word)
						report_mismatch("spin_word", rsp.spin_word, oldest.spin_word);
					if (rsp.flip_mask !== oldest.flip_mask)
						report_mismatch("flip_mask", rsp.flip_mask, oldest.flip_mask);
				end
			end
			if (req.valid && req.ready)
				in_flight.push_back(apply_request(op_t'(req.operation), req.site,
					bond_t'(req.bond), req.word, req.random_draw));
		end
		outstanding <= in_flight.size();
	end

endmodule

@@ tb/tb_multispin_ising_metropolis_update.sv @@
`timescale 1ns / 100ps
// Top of the testbench for multispin_ising_metropolis_update: clock, reset, table
// programming and request/result traffic; the checker beside the block does the prediction.
// Depends on msi_pkg, msi_req_if, msi_rsp_if, msi_update_checker and the block itself.
module tb_multispin_ising_metropolis_update;
	import msi_pkg::*;

	// The settle gives the block time to go quiet after the last result.
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int RESET_CYCLES    = 11;
	localparam int PHASE_WORDS     = 210;
	localparam int N_PHASES        = 5;
	localparam int N_FOCUS         = 24;

	// Register indexes past the last one; writes there must leave the table alone.
	localparam cfg_idx_t CFG_SPARE_LO = cfg_idx_t'(int'(CFG_ALWAYS) + 1);
	localparam cfg_idx_t CFG_SPARE_HI = cfg_idx_t'(int'(CFG_ALWAYS) + 2);

	typedef enum {TBL_NONE, TBL_FULL, TBL_ALWAYS, TBL_RANDOM} table_mode_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	word_t    cfg_data;
	int       outstanding;
	int       errors;
	int       cycle_count;
	bit       hold_off_req;

	// Which words have been written at least once. Reads and updates only ever touch
	// words that are known, since a never-written word has no defined value.
	bit spin_known [NSITES];
	bit coup_known [NSITES][N_BOND];
	int focus      [N_FOCUS];

	table_mode_t phase_mode [N_PHASES] = '{TBL_NONE, TBL_FULL, TBL_ALWAYS, TBL_RANDOM,
		TBL_RANDOM};

	msi_req_if req_ch ();
	msi_rsp_if rsp_ch ();

	multispin_ising_metropolis_update uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	msi_update_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.outstanding (outstanding),
		.errors      (errors)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Spin and coupling contents: solid words, sparse words and plain random words.
	function automatic word_t spin_pattern();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return ALL_ONES;
		if (r < 30)
			return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		return {$urandom, $urandom};
	endfunction

	function automatic draw_t draw_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return ~draw_t'(0);
		return draw_t'($urandom);
	endfunction

	function automatic int north_of(int s);
		return (s < SIDE) ? s + NSITES - SIDE : s - SIDE;
	endfunction

	function automatic int south_of(int s);
		return (s + SIDE < NSITES) ? s + SIDE : s + SIDE - NSITES;
	endfunction

	// Finds the first word an update of site s would read that was never written.
	function automatic bit find_missing(input int s, output op_t op, output int at,
		output bond_t b);
		int col, k;
		int deps [5];
		col     = s % SIDE;
		deps[0] = s;
		deps[1] = (col != 0) ? s - 1 : s;
		deps[2] = (col != SIDE - 1) ? s + 1 : s;
		deps[3] = north_of(s);
		deps[4] = south_of(s);
		b       = BOND_W;
		for (k = 0; k < 5; k++)
			if (!spin_known[deps[k]]) begin
				op = OP_WR_SPIN;
				at = deps[k];
				return 1'b1;
			end
		// All four coupling words are written even at the row ends, so the block
		// never reads an undefined coupling row.
		for (k = 0; k < N_BOND; k++)
			if (!coup_known[s][k]) begin
				op = OP_WR_COUP;
				at = s;
				b  = bond_t'(k);
				return 1'b1;
			end
		op = OP_RD_SPIN;
		at = s;
		return 1'b0;
	endfunction

	// Offers one request word and returns at the edge where the block takes it.
	// Must be called at a rising edge; each call leaves valid high for the next one.
	task automatic offer(op_t op, int at, bond_t b, word_t w, draw_t d);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (op == OP_WR_SPIN)
			spin_known[at] = 1'b1;
		else if (op == OP_WR_COUP)
			coup_known[at][b] = 1'b1;
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.site        <= site_t'(at);
		req_ch.bond        <= b;
		req_ch.word        <= w;
		req_ch.random_draw <= d;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, word_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Loads all five threshold registers and the always flags. The spare indexes get
	// all ones, which would wreck the table if the block decoded them.
	task automatic program_table(table_mode_t mode);
		word_t thr_word;
		word_t flags;
		int    i;
		for (i = 0; i < N_THR_REG; i++) begin
			case (mode)
				TBL_NONE: thr_word = '0;
				TBL_FULL: thr_word = ALL_ONES;
				default:  thr_word = {$urandom, $urandom};
			endcase
			write_reg(cfg_idx_t'(int'(CFG_THR_A) + i), thr_word);
		end
		// Bits above the twenty flags carry junk; they are not part of the register.
		flags = {$urandom, $urandom};
		case (mode)
			TBL_ALWAYS: flags[N_ENTRY-1:0] = '1;
			TBL_RANDOM: ;
			default:    flags[N_ENTRY-1:0] = '0;
		endcase
		write_reg(CFG_ALWAYS, flags);
		write_reg(CFG_SPARE_LO, ALL_ONES);
		write_reg(CFG_SPARE_HI, ALL_ONES);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Returns once every predicted result word has come back and the block is quiet.
	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both lattice corners: row ends on either side, north wrap at the top row and
	// south wrap at the bottom row, extreme words and extreme draws.
	task automatic directed_words();
		int k;
		offer(OP_WR_SPIN, 0, BOND_S, ALL_ONES, ~draw_t'(0));
		offer(OP_WR_SPIN, 1, BOND_W, '0, '0);
		offer(OP_WR_SPIN, north_of(0), BOND_N, spin_pattern(), draw_pick());
		offer(OP_WR_SPIN, south_of(0), BOND_E, {16{4'h5}}, draw_pick());
		for (k = 0; k < N_BOND; k++)
			offer(OP_WR_COUP, 0, bond_t'(k), (k == 0) ? ALL_ONES : (k == 1) ? '0 :
				spin_pattern(), draw_pick());
		// Bond and word carry junk on updates and reads; the block must ignore them.
		offer(OP_UPDATE, 0, BOND_S, ALL_ONES, '0);
		offer(OP_UPDATE, 0, BOND_W, '0, ~draw_t'(0));
		offer(OP_RD_SPIN, 0, BOND_E, ALL_ONES, ~draw_t'(0));
		offer(OP_WR_SPIN, NSITES - 1, BOND_N, spin_pattern(), draw_pick());
		offer(OP_WR_SPIN, NSITES - 2, BOND_S, spin_pattern(), draw_pick());
		offer(OP_WR_SPIN, north_of(NSITES - 1), BOND_W, spin_pattern(), draw_pick());
		offer(OP_WR_SPIN, south_of(NSITES - 1), BOND_E, ALL_ONES, draw_pick());
		for (k = 0; k < N_BOND; k++)
			offer(OP_WR_COUP, NSITES - 1, bond_t'(k), spin_pattern(), draw_pick());
		offer(OP_UPDATE, NSITES - 1, BOND_N, spin_pattern(), draw_pick());
		offer(OP_RD_SPIN, NSITES - 1, BOND_W, '0, '0);
		// A coupling write answers with the site's current, already updated spin word.
		offer(OP_WR_COUP, 0, BOND_N, spin_pattern(), draw_pick());
	endtask

	// Mostly updates on a pool of sites, with the words they depend on written first.
	// Neighbor and coupling rewrites keep the neighborhoods changing between updates,
	// and writes anywhere in the lattice move every bit of the site field. A coupling
	// write answers with the site's spin word, so it only goes to sites already written.
	task automatic random_traffic(int count);
		int    n, r, s, at, col;
		op_t   op;
		bond_t b;
		for (n = 0; n < count; n++) begin
			s = focus[$urandom_range(0, N_FOCUS - 1)];
			if (find_missing(s, op, at, b)) begin
				offer(op, at, b, spin_pattern(), draw_pick());
				continue;
			end
			col = s % SIDE;
			r   = $urandom_range(0, 99);
			if (r < 55) begin
				offer(OP_UPDATE, s, bond_t'($urandom_range(0, 3)), spin_pattern(), draw_pick());
			end else if (r < 65) begin
				case ($urandom_range(0, 4))
					0:       at = s;
					1:       at = (col != 0) ? s - 1 : s;
					2:       at = (col != SIDE - 1) ? s + 1 : s;
					3:       at = north_of(s);
					default: at = south_of(s);
				endcase
				offer(OP_WR_SPIN, at, bond_t'($urandom_range(0, 3)), spin_pattern(), draw_pick());
			end else if (r < 73) begin
				offer(OP_WR_COUP, s, bond_t'($urandom_range(0, 3)), spin_pattern(), draw_pick());
			end else if (r < 83) begin
				offer(OP_RD_SPIN, s, bond_t'($urandom_range(0, 3)), spin_pattern(), draw_pick());
			end else if (r < 93) begin
				at = $urandom_range(0, NSITES - 1);
				offer((($urandom_range(0, 1) != 0) || !spin_known[at]) ? OP_WR_SPIN :
					OP_WR_COUP, at, bond_t'($urandom_range(0, 3)), spin_pattern(),
					draw_pick());
			end else begin
				at = $urandom_range(0, NSITES - 1);
				offer(spin_known[at] ? OP_RD_SPIN : OP_WR_SPIN, at,
					bond_t'($urandom_range(0, 3)), spin_pattern(), draw_pick());
			end
		end
	endtask

	// Result side: runs of ready, random stalls, and one long hold-off on request.
	initial begin
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 99) < 55) begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat (idle_len() + 1) @(posedge clk);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_multispin_ising_metropolis_update: FAIL");
		$finish;
	end

	initial begin
		int p, i;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_THR_A;
		cfg_data           <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.operation   <= OP_RD_SPIN;
		req_ch.site        <= '0;
		req_ch.bond        <= BOND_W;
		req_ch.word        <= '0;
		req_ch.random_draw <= '0;
		hold_off_req        = 1'b0;

		// The pool mixes both row ends, both wrap rows and interior sites, and
		// includes neighboring pairs so one update sees the other's flips.
		focus[0] = 0;
		focus[1] = 1;
		focus[2] = SIDE - 2;
		focus[3] = SIDE - 1;
		focus[4] = NSITES - SIDE;
		focus[5] = NSITES - 1;
		focus[6] = SIDE + 1;
		focus[7] = NSITES / 2 + SIDE / 2;
		for (i = 8; i < N_FOCUS; i++)
			focus[i] = $urandom_range(0, NSITES - 1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_table(TBL_RANDOM);
		directed_words();

		// Each phase runs under its own table, from nothing ever flipping, through
		// full thresholds and forced acceptance, to random tables.
		for (p = 0; p < N_PHASES; p++) begin
			req_ch.valid <= 1'b0;
			wait_drained();
			program_table(phase_mode[p]);
			// Stall the result side long enough for the block to back up its input.
			if (p == 2)
				hold_off_req = 1'b1;
			random_traffic(PHASE_WORDS);
		end
		req_ch.valid <= 1'b0;
		wait_drained();

		if (errors == 0)
			$display("tb_multispin_ising_metropolis_update: PASS");
		else
			$display("tb_multispin_ising_metropolis_update: FAIL");
		$finish;
	end

endmodule
